// ===== src/x86enc_pkg.sv =====
package x86enc_pkg;

   localparam int MaxBytes = 15;
   localparam int CntW     = 4;

   typedef enum logic [2:0] {
      FUNC_STORE   = 3'd0,
      FUNC_LOAD    = 3'd1,
      FUNC_MOVIMM  = 3'd2,
      FUNC_CALLREL = 3'd3,
      FUNC_CALLIND = 3'd4,
      FUNC_CALLFAR = 3'd5,
      FUNC_NOP     = 3'd6,
      FUNC_SPARE   = 3'd7
   } func_type;

   localparam logic [7:0] PFX_OPSIZE = 8'h66;
   localparam logic [7:0] PFX_ADDR32 = 8'h67;
   localparam logic [7:0] REX_BASE   = 8'h40;
   localparam logic [7:0] OP_CALLREL = 8'hE8;
   localparam logic [7:0] OP_GRP5    = 8'hFF;
   localparam logic [7:0] OP_MOVRM   = 8'h88;
   localparam logic [7:0] OP_MOFFS   = 8'hA0;
   localparam logic [7:0] OP_MOVIRM  = 8'hC6;
   localparam logic [7:0] OP_MOVIB   = 8'hB0;
   localparam logic [7:0] OP_MOVIV   = 8'hB8;
   localparam logic [7:0] OP_NOP     = 8'h90;

   // one instruction, fully laid out; bytes[0] goes first
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CntW-1:0]          len;    // byte count, 1..15
      logic                     fault;
   } insn_type;

endpackage

// ===== src/x86enc_front.sv =====
module x86enc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [2:0]            func,
   input  logic [1:0]            op_size,
   input  logic [3:0]            reg_num,
   input  logic                  rm_is_reg,
   input  logic                  has_base,
   input  logic [3:0]            base_reg,
   input  logic                  has_index,
   input  logic [3:0]            index_reg,
   input  logic                  addr_32,
   input  logic [3:0]            scale,
   input  logic [63:0]           displacement,
   input  logic [63:0]           imm,
   output logic                  out_valid,
   input  logic                  out_ready,
   output x86enc_pkg::insn_type  out_insn
);
   import x86enc_pkg::*;

   logic     valid_ff, valid_in;
   insn_type insn_ff, insn_in;

   logic [MaxBytes-1:0][7:0] buf_b;
   logic [CntW-1:0]          n;
   logic                     idx_used;
   logic [1:0]               ss;
   logic [31:0]              d32;
   func_type                 fn;

   always_comb begin
      fn = func_type'(func);
      idx_used = has_index && (scale != 4'd0);
      if (scale >= 4'd8)      ss = 2'd3;
      else if (scale >= 4'd4) ss = 2'd2;
      else if (scale >= 4'd2) ss = 2'd1;
      else                    ss = 2'd0;
      d32 = displacement[31:0];
   end

   // builds the byte string; each put is a position mux on a narrow count
   always_comb begin
      logic       rmi, wordp, rexw, sib, wide, fault, movrm;
      logic [3:0] regf, rex;
      logic [7:0] opc;
      logic [1:0] mode;
      logic [2:0] b;
      logic [3:0] isz;
      buf_b = '0;
      n     = '0;
      rmi = 1'b0; wordp = 1'b0; rexw = 1'b0; regf = 4'd0; opc = 8'h00;
      rex = 4'd0; mode = 2'd0; sib = 1'b0; b = base_reg[2:0]; isz = 4'd0;
      wide = (displacement + 64'h8000_0000) >> 32 != 64'd0;
      fault = !rm_is_reg && idx_used && index_reg == 4'd4 &&
              (fn == FUNC_STORE || fn == FUNC_LOAD || fn == FUNC_MOVIMM ||
               fn == FUNC_CALLIND || fn == FUNC_CALLFAR);
      movrm = 1'b0;
      unique case (fn)
         FUNC_STORE, FUNC_LOAD: begin
            if (reg_num == 4'd0 && !rm_is_reg && !has_base && !idx_used && wide) begin
               if (op_size == 2'd1) begin buf_b[n] = PFX_OPSIZE; n = n + 1'b1; end
               if (op_size == 2'd3) begin buf_b[n] = REX_BASE | 8'h08; n = n + 1'b1; end
               buf_b[n] = OP_MOFFS + ((fn == FUNC_STORE) ? 8'd2 : 8'd0)
                          + {7'd0, op_size != 2'd0};
               n = n + 1'b1;
               for (int i = 0; i < 8; i++) begin
                  buf_b[n] = displacement[8*i +: 8];
                  n = n + 1'b1;
               end
            end else begin
               rmi = 1'b1; regf = reg_num; wordp = op_size == 2'd1;
               rexw = op_size == 2'd3;
               opc = OP_MOVRM + ((fn == FUNC_LOAD) ? 8'd2 : 8'd0)
                     + {7'd0, op_size != 2'd0};
            end
         end
         FUNC_MOVIMM: begin
            isz = (op_size == 2'd0) ? 4'd1 : (op_size == 2'd1) ? 4'd2 : 4'd4;
            if (!rm_is_reg || (op_size == 2'd3 && imm <= 64'h7fff_ffff)) begin
               rmi = 1'b1; movrm = 1'b1; regf = 4'd0; wordp = op_size == 2'd1;
               rexw = op_size == 2'd3;
               opc = OP_MOVIRM + {7'd0, op_size != 2'd0};
            end else begin
               if (op_size == 2'd1) begin buf_b[n] = PFX_OPSIZE; n = n + 1'b1; end
               rex = {op_size == 2'd3, 2'b00, base_reg[3]};
               if (rex != 4'd0) begin buf_b[n] = REX_BASE | {4'd0, rex}; n = n + 1'b1; end
               buf_b[n] = ((op_size == 2'd0) ? OP_MOVIB : OP_MOVIV) + {5'd0, b};
               n = n + 1'b1;
               if (op_size == 2'd3) isz = 4'd8;
               for (int i = 0; i < 8; i++) begin
                  if (4'(i) < isz) begin buf_b[n] = imm[8*i +: 8]; n = n + 1'b1; end
               end
            end
         end
         FUNC_CALLREL: begin
            if (op_size == 2'd1) begin buf_b[n] = PFX_OPSIZE; n = n + 1'b1; end
            buf_b[n] = OP_CALLREL; n = n + 1'b1;
            for (int i = 0; i < 4; i++) begin
               if (op_size != 2'd1 || i < 2) begin
                  buf_b[n] = displacement[8*i +: 8]; n = n + 1'b1;
               end
            end
         end
         FUNC_CALLIND, FUNC_CALLFAR: begin
            rmi = 1'b1; regf = (fn == FUNC_CALLIND) ? 4'd2 : 4'd3;
            wordp = op_size == 2'd1; opc = OP_GRP5;
         end
         default: begin buf_b[n] = OP_NOP; n = n + 1'b1; end
      endcase
      if (rmi) begin
         if (!rm_is_reg && addr_32 && (has_base || idx_used)) begin
            buf_b[n] = PFX_ADDR32; n = n + 1'b1;
         end
         if (wordp) begin buf_b[n] = PFX_OPSIZE; n = n + 1'b1; end
         rex = {rexw, regf[3], !rm_is_reg && idx_used && index_reg[3],
                (rm_is_reg || has_base) && base_reg[3]};
         if (rex != 4'd0) begin buf_b[n] = REX_BASE | {4'd0, rex}; n = n + 1'b1; end
         buf_b[n] = opc; n = n + 1'b1;
         if (rm_is_reg) begin
            buf_b[n] = {2'b11, regf[2:0], b}; n = n + 1'b1;
         end else if (!has_base) begin
            buf_b[n] = {2'b00, regf[2:0], 3'b100}; n = n + 1'b1;
            buf_b[n] = idx_used ? {ss, index_reg[2:0], 3'b101} : 8'h25;
            n = n + 1'b1;
            for (int i = 0; i < 4; i++) begin buf_b[n] = d32[8*i +: 8]; n = n + 1'b1; end
         end else begin
            if (d32 == 32'd0 && b != 3'd5) mode = 2'd0;
            else if (d32 + 32'd128 < 32'd256) mode = 2'd1;
            else mode = 2'd2;
            sib = idx_used || b == 3'd4;
            buf_b[n] = {mode, regf[2:0], sib ? 3'b100 : b}; n = n + 1'b1;
            if (sib) begin
               buf_b[n] = idx_used ? {ss, index_reg[2:0], b} : {2'b00, 3'b100, b};
               n = n + 1'b1;
            end
            for (int i = 0; i < 4; i++) begin
               if ((mode == 2'd1 && i == 0) || mode == 2'd2) begin
                  buf_b[n] = d32[8*i +: 8]; n = n + 1'b1;
               end
            end
         end
         if (movrm) begin
            for (int i = 0; i < 4; i++) begin
               if (4'(i) < isz) begin buf_b[n] = imm[8*i +: 8]; n = n + 1'b1; end
            end
         end
      end
      insn_in.fault = fault;
      if (fault) begin
         insn_in.bytes = '0;
         insn_in.len   = 4'd1;
      end else begin
         insn_in.bytes = buf_b;
         insn_in.len   = n;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (in_ready && in_valid) insn_ff <= insn_in;
   end

   assign out_valid = valid_ff;
   assign out_insn  = insn_ff;

endmodule

// ===== src/x86enc_queue.sv =====
module x86enc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  x86enc_pkg::insn_type  in_insn,
   output logic                  out_valid,
   input  logic                  out_ready,
   output x86enc_pkg::insn_type  out_insn
);
   import x86enc_pkg::*;

   insn_type  slot_ff [2];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_insn = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= in_insn;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("full queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_insn.len != 4'd0))
      else $error("empty instruction queued");

endmodule

// ===== src/x86enc_back.sv =====
module x86enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  x86enc_pkg::insn_type  in_insn,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_byte,
   output logic                  out_last,
   output logic                  out_fault
);
   import x86enc_pkg::*;

   logic [CntW-1:0] pos_ff, pos_in;
   logic            is_last;

   assign is_last   = (pos_ff + 1'b1) == in_insn.len;
   assign out_valid = in_valid;
   assign out_byte  = in_insn.bytes[pos_ff];
   assign out_last  = is_last;
   assign out_fault = in_insn.fault;
   assign in_ready  = out_ready && is_last;

   always_comb begin
      pos_in = pos_ff;
      if (in_valid && out_ready) pos_in = is_last ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else       pos_ff <= pos_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> pos_ff == $past(pos_ff))
      else $error("byte index moved while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_fault) |-> out_last)
      else $error("fault word not last");
   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> pos_ff < in_insn.len)
      else $error("byte index past length");

endmodule

// ===== src/x86_64_instruction_encoder_unit.sv =====
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | req_tdata: instruction descriptor
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata byte, rsp_tlast, rsp_tuser fault
//
// One instruction word is accepted per cycle, unless the queue is full, into a
// registered encode stage; a two-entry queue feeds the byte sequencer, which
// sends one byte a cycle while rsp_tready is high, N bytes (1..15) per instruction.
// Sync active-high reset empties every stage; no warm-up pass.
// Either side can stall freely; the queue absorbs front/back mismatch.
module x86_64_instruction_encoder_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // func[2:0] op_size[4:3] reg_num[8:5] rm_is_reg[9] has_base[10]
   // base_reg[14:11] has_index[15] index_reg[19:16] addr_32[20] scale[24:21]
   // displacement[88:25] imm[152:89], zero fill to 160
   input  logic [159:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // code_byte[7:0]
   output logic          rsp_tlast,
   output logic          rsp_tuser    // fault[0]
);
   import x86enc_pkg::*;

   logic     f_valid, f_ready, q_valid, q_ready;
   insn_type f_insn, q_insn;

   x86enc_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .func(req_tdata[2:0]), .op_size(req_tdata[4:3]), .reg_num(req_tdata[8:5]),
      .rm_is_reg(req_tdata[9]), .has_base(req_tdata[10]),
      .base_reg(req_tdata[14:11]), .has_index(req_tdata[15]),
      .index_reg(req_tdata[19:16]), .addr_32(req_tdata[20]),
      .scale(req_tdata[24:21]), .displacement(req_tdata[88:25]),
      .imm(req_tdata[152:89]),
      .out_valid(f_valid), .out_ready(f_ready), .out_insn(f_insn)
   );

   x86enc_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_insn(f_insn),
      .out_valid(q_valid), .out_ready(q_ready), .out_insn(q_insn)
   );

   x86enc_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_insn(q_insn),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_byte(rsp_tdata), .out_last(rsp_tlast), .out_fault(rsp_tuser)
   );

endmodule
